[hdl/dvfv_pkg.sv]
// types, constants and lookup functions shared by the value field validator
`default_nettype none

package dvfv_pkg;

  // value representation codes
  localparam logic [4:0] VR_AE = 5'd0;
  localparam logic [4:0] VR_AS = 5'd1;
  localparam logic [4:0] VR_AT = 5'd2;
  localparam logic [4:0] VR_CS = 5'd3;
  localparam logic [4:0] VR_DA = 5'd4;
  localparam logic [4:0] VR_DS = 5'd5;
  localparam logic [4:0] VR_DT = 5'd6;
  localparam logic [4:0] VR_FL = 5'd7;
  localparam logic [4:0] VR_FD = 5'd8;
  localparam logic [4:0] VR_IS = 5'd9;
  localparam logic [4:0] VR_LO = 5'd10;
  localparam logic [4:0] VR_LT = 5'd11;
  localparam logic [4:0] VR_OB = 5'd12;
  localparam logic [4:0] VR_OF = 5'd13;
  localparam logic [4:0] VR_OW = 5'd14;
  localparam logic [4:0] VR_PN = 5'd15;
  localparam logic [4:0] VR_SH = 5'd16;
  localparam logic [4:0] VR_SL = 5'd17;
  localparam logic [4:0] VR_SQ = 5'd18;
  localparam logic [4:0] VR_SS = 5'd19;
  localparam logic [4:0] VR_ST = 5'd20;
  localparam logic [4:0] VR_TM = 5'd21;
  localparam logic [4:0] VR_UI = 5'd22;
  localparam logic [4:0] VR_UL = 5'd23;
  localparam logic [4:0] VR_UN = 5'd24;
  localparam logic [4:0] VR_US = 5'd25;
  localparam logic [4:0] VR_UT = 5'd26;

  // byte values with a meaning of their own
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_D   = 8'h44;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_UP_M   = 8'h4D;
  localparam logic [7:0] CH_UP_W   = 8'h57;
  localparam logic [7:0] CH_UP_Y   = 8'h59;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  // widths and limits
  localparam int unsigned LIM_BITS   = 14;
  localparam int unsigned COMP_BITS  = 7;
  localparam int unsigned VALUE_BITS = 32;

  localparam logic [COMP_BITS-1:0] COMP_SAT     = 7'd127;
  localparam logic [COMP_BITS-1:0] DA_LEN_SHORT = 7'd8;
  localparam logic [COMP_BITS-1:0] DA_LEN_LONG  = 7'd10;

  localparam logic [LIM_BITS-1:0] LIM_NONE  = 14'd0;
  localparam logic [LIM_BITS-1:0] LIM_IS    = 14'd12;
  localparam logic [LIM_BITS-1:0] LIM_SHORT = 14'd16;
  localparam logic [LIM_BITS-1:0] LIM_DT    = 14'd26;
  localparam logic [LIM_BITS-1:0] LIM_LONG  = 14'd64;
  localparam logic [LIM_BITS-1:0] LIM_ST    = 14'd1024;
  localparam logic [LIM_BITS-1:0] LIM_LT    = 14'd10240;
  localparam logic [LIM_BITS-1:0] UNIT_2    = 14'd2;
  localparam logic [LIM_BITS-1:0] UNIT_4    = 14'd4;
  localparam logic [LIM_BITS-1:0] UNIT_8    = 14'd8;

  // age string layout
  localparam int unsigned AGE_DIGITS = 3;
  localparam int unsigned AGE_LEN    = 4;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_STR  = 3'd1,
    KIND_TEXT = 3'd2,
    KIND_AGE  = 3'd3,
    KIND_BIN  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    CLS_PRINT = 3'd0,
    CLS_CS    = 3'd1,
    CLS_DATE  = 3'd2,
    CLS_DS    = 3'd3,
    CLS_DT    = 3'd4,
    CLS_IS    = 3'd5,
    CLS_TEXT  = 3'd6
  } cls_t;

  typedef struct packed {
    kind_t               kind;
    cls_t                cls;
    logic                lead;
    logic                trail;
    logic [LIM_BITS-1:0] lim;
  } vr_info_t;

  typedef struct packed {
    logic [4:0] vr_code;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_element;
  } in_item_t;

  typedef struct packed {
    logic                  valid_res;
    logic [VALUE_BITS-1:0] multiplicity;
  } out_item_t;

  // per-component string state
  typedef struct packed {
    logic [COMP_BITS-1:0]  component_length;
    logic [VALUE_BITS-1:0] value_count;
    logic                  in_leading_spaces;
    logic                  pending_spaces;
    logic                  bad_seen;
  } str_state_t;

  function automatic vr_info_t mk_info(kind_t kind, cls_t cls, logic lead, logic trail,
                                       logic [LIM_BITS-1:0] lim);
    vr_info_t r;
    r.kind  = kind;
    r.cls   = cls;
    r.lead  = lead;
    r.trail = trail;
    r.lim   = lim;
    return r;
  endfunction

  // rules for each value representation
  function automatic vr_info_t vr_lookup(logic [4:0] code);
    vr_info_t r;
    case (code)
      VR_AE:   r = mk_info(KIND_STR,  CLS_PRINT, 1'b1, 1'b1, LIM_SHORT);
      VR_AS:   r = mk_info(KIND_AGE,  CLS_PRINT, 1'b0, 1'b0, LIM_NONE);
      VR_AT:   r = mk_info(KIND_BIN,  CLS_PRINT, 1'b0, 1'b0, UNIT_4);
      VR_CS:   r = mk_info(KIND_STR,  CLS_CS,    1'b1, 1'b1, LIM_SHORT);
      VR_DA:   r = mk_info(KIND_STR,  CLS_DATE,  1'b0, 1'b1, LIM_NONE);
      VR_DS:   r = mk_info(KIND_STR,  CLS_DS,    1'b1, 1'b1, LIM_SHORT);
      VR_DT:   r = mk_info(KIND_STR,  CLS_DT,    1'b0, 1'b1, LIM_DT);
      VR_FL:   r = mk_info(KIND_BIN,  CLS_PRINT, 1'b0, 1'b0, UNIT_4);
      VR_FD:   r = mk_info(KIND_BIN,  CLS_PRINT, 1'b0, 1'b0, UNIT_8);
      VR_IS:   r = mk_info(KIND_STR,  CLS_IS,    1'b1, 1'b1, LIM_IS);
      VR_LO:   r = mk_info(KIND_STR,  CLS_TEXT,  1'b0, 1'b0, LIM_LONG);
      VR_LT:   r = mk_info(KIND_TEXT, CLS_PRINT, 1'b0, 1'b0, LIM_LT);
      VR_PN:   r = mk_info(KIND_STR,  CLS_TEXT,  1'b0, 1'b1, LIM_LONG);
      VR_SH:   r = mk_info(KIND_STR,  CLS_TEXT,  1'b0, 1'b0, LIM_SHORT);
      VR_SL:   r = mk_info(KIND_BIN,  CLS_PRINT, 1'b0, 1'b0, UNIT_4);
      VR_SS:   r = mk_info(KIND_BIN,  CLS_PRINT, 1'b0, 1'b0, UNIT_2);
      VR_ST:   r = mk_info(KIND_TEXT, CLS_PRINT, 1'b0, 1'b0, LIM_ST);
      VR_TM:   r = mk_info(KIND_STR,  CLS_DATE,  1'b0, 1'b1, LIM_SHORT);
      VR_UI:   r = mk_info(KIND_STR,  CLS_DATE,  1'b0, 1'b0, LIM_LONG);
      VR_UL:   r = mk_info(KIND_BIN,  CLS_PRINT, 1'b0, 1'b0, UNIT_4);
      VR_US:   r = mk_info(KIND_BIN,  CLS_PRINT, 1'b0, 1'b0, UNIT_2);
      VR_UT:   r = mk_info(KIND_TEXT, CLS_PRINT, 1'b0, 1'b0, LIM_NONE);
      default: r = mk_info(KIND_NONE, CLS_PRINT, 1'b0, 1'b0, LIM_NONE);
    endcase
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_print(logic [7:0] b);
    return b inside {[CH_SPACE:CH_TILDE]};
  endfunction

  // character class of string components
  function automatic logic class_ok(cls_t cls, logic [7:0] b);
    logic ok;
    case (cls)
      CLS_PRINT: ok = is_print(b);
      CLS_CS:    ok = is_digit(b) || (b inside {CH_SPACE, CH_UNDER, [CH_UP_A:CH_UP_Z]});
      CLS_DATE:  ok = is_digit(b) || (b == CH_DOT);
      CLS_DS:    ok = is_digit(b) || (b inside {CH_DOT, CH_PLUS, CH_MINUS, CH_LO_E, CH_UP_E});
      CLS_DT:    ok = is_digit(b) || (b inside {CH_DOT, CH_PLUS, CH_MINUS});
      CLS_IS:    ok = is_digit(b) || (b inside {CH_PLUS, CH_MINUS});
      default:   ok = is_print(b) || (b == CH_ESC);
    endcase
    return ok;
  endfunction

  // character class of free text
  function automatic logic text_ok(logic [7:0] b);
    return is_print(b) || (b inside {CH_LF, CH_FF, CH_CR, CH_ESC});
  endfunction

  function automatic logic age_unit_ok(logic [7:0] b);
    return b inside {CH_UP_D, CH_UP_W, CH_UP_M, CH_UP_Y};
  endfunction

endpackage

`default_nettype wire

[hdl/dvfv_channels.sv]
// valid/ready channel interfaces for value bytes and element results
`default_nettype none

interface dvfv_in_if import dvfv_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dvfv_out_if import dvfv_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/dicom_value_field_validator.sv]
// value field validator top level: byte register, check logic, result register
// the last byte of an element passes the byte register, then the element's result is registered in the result register
// throughput: one value byte per cycle unless the input stalls, the running state is registered for each byte
// input stalls only when an element end waits behind an untaken result
// rst (synchronous) clears the handshake state and the running counters and flags
`default_nettype none

module dicom_value_field_validator import dvfv_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  dvfv_in_if.sink           in_ch,
  dvfv_out_if.source        out_ch
);

  // input register
  logic     s1_valid;
  in_item_t s1_item;

  // running element state
  logic [LENGTH_BITS-1:0] byte_count;
  str_state_t             str_st;
  logic                   string_ended;
  logic                   age_ok;

  logic [LENGTH_BITS-1:0] byte_count_next;
  str_state_t             str_st_next;
  logic                   string_ended_next;
  logic                   age_ok_next;

  // result register
  logic      out_valid;
  out_item_t out_item;
  out_item_t res;

  vr_info_t   info;
  logic       s1_ends;
  logic       s1_adv;
  str_state_t str_fin;
  logic [7:0] b;

  // closes a string component and checks its length
  function automatic str_state_t end_comp(str_state_t s, vr_info_t vi);
    str_state_t r;
    r = s;
    if (s.component_length != '0) begin
      if (s.value_count != '1) begin
        r.value_count = s.value_count + 1'b1;
      end
      if (vi.lim == LIM_NONE) begin
        if (s.component_length != DA_LEN_SHORT && s.component_length != DA_LEN_LONG) begin
          r.bad_seen = 1'b1;
        end
      end else if ({{(LIM_BITS-COMP_BITS){1'b0}}, s.component_length} > vi.lim) begin
        r.bad_seen = 1'b1;
      end
    end
    r.component_length  = '0;
    r.in_leading_spaces = 1'b1;
    r.pending_spaces    = 1'b0;
    return r;
  endfunction

  assign info    = vr_lookup(s1_item.vr_code);
  assign b       = s1_item.data_byte;
  assign s1_ends = s1_item.last_byte || s1_item.empty_element;
  assign s1_adv  = s1_valid && (!s1_ends || !out_valid || out_ch.ready);

  assign in_ch.ready  = !s1_valid || s1_adv;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

  // byte check and state update
  always_comb begin
    byte_count_next   = byte_count;
    str_st_next       = str_st;
    string_ended_next = string_ended;
    age_ok_next       = age_ok;
    if (!s1_item.empty_element) begin
      case (info.kind)
        KIND_STR: begin
          if (!string_ended) begin
            if (b == CH_NUL) begin
              str_st_next       = end_comp(str_st, info);
              string_ended_next = 1'b1;
            end else if (b == CH_BSLASH) begin
              str_st_next = end_comp(str_st, info);
            end else begin
              if (str_st.component_length < COMP_SAT) begin
                str_st_next.component_length = str_st.component_length + 1'b1;
              end
              if (b == CH_SPACE) begin
                if (info.lead && str_st.in_leading_spaces) begin
                  str_st_next.bad_seen = str_st.bad_seen;
                end else if (info.trail) begin
                  str_st_next.pending_spaces = 1'b1;
                end else if (!class_ok(info.cls, b)) begin
                  str_st_next.bad_seen = 1'b1;
                end
              end else begin
                // held trailing spaces turn out to be inner spaces
                if ((str_st.pending_spaces && !class_ok(info.cls, CH_SPACE)) ||
                    !class_ok(info.cls, b)) begin
                  str_st_next.bad_seen = 1'b1;
                end
                str_st_next.pending_spaces    = 1'b0;
                str_st_next.in_leading_spaces = 1'b0;
              end
            end
          end
        end
        KIND_TEXT: begin
          if (!text_ok(b)) begin
            str_st_next.bad_seen = 1'b1;
          end
        end
        KIND_AGE: begin
          if (byte_count < LENGTH_BITS'(AGE_DIGITS)) begin
            if (!is_digit(b)) begin
              age_ok_next = 1'b0;
            end
          end else if (byte_count == LENGTH_BITS'(AGE_DIGITS)) begin
            if (!age_unit_ok(b)) begin
              age_ok_next = 1'b0;
            end
          end
        end
        default: begin
          age_ok_next = age_ok;
        end
      endcase
      if (byte_count != '1) begin
        byte_count_next = byte_count + 1'b1;
      end
    end
  end

  // element result under the code of the ending transfer
  always_comb begin
    str_fin          = end_comp(str_st_next, info);
    res.valid_res    = !str_st_next.bad_seen;
    res.multiplicity = '0;
    case (info.kind)
      KIND_STR: begin
        res.valid_res    = !str_fin.bad_seen;
        res.multiplicity = str_fin.value_count;
      end
      KIND_TEXT: begin
        res.valid_res    = !str_st_next.bad_seen &&
                           (info.lim == LIM_NONE ||
                            byte_count_next <= LENGTH_BITS'(info.lim));
        res.multiplicity = VALUE_BITS'(1);
      end
      KIND_AGE: begin
        res.valid_res    = !str_st_next.bad_seen && age_ok_next &&
                           byte_count_next == LENGTH_BITS'(AGE_LEN);
        res.multiplicity = VALUE_BITS'(1);
      end
      KIND_BIN: begin
        case (info.lim)
          UNIT_2: begin
            res.valid_res    = !str_st_next.bad_seen && !byte_count_next[0];
            res.multiplicity = VALUE_BITS'(byte_count_next >> 1);
          end
          UNIT_4: begin
            res.valid_res    = !str_st_next.bad_seen && byte_count_next[1:0] == 2'd0;
            res.multiplicity = VALUE_BITS'(byte_count_next >> 2);
          end
          default: begin
            res.valid_res    = !str_st_next.bad_seen && byte_count_next[2:0] == 3'd0;
            res.multiplicity = VALUE_BITS'(byte_count_next >> 3);
          end
        endcase
      end
      default: begin
        res.valid_res    = !str_st_next.bad_seen;
        res.multiplicity = '0;
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      s1_item <= in_ch.data;
    end
  end

  // running state, back to reset values after each element
  always_ff @(posedge clk) begin
    if (rst || (s1_adv && s1_ends)) begin
      byte_count                 <= '0;
      str_st.component_length    <= '0;
      str_st.value_count         <= '0;
      str_st.in_leading_spaces   <= 1'b1;
      str_st.pending_spaces      <= 1'b0;
      str_st.bad_seen            <= 1'b0;
      string_ended               <= 1'b0;
      age_ok                     <= 1'b1;
    end else if (s1_adv) begin
      byte_count   <= byte_count_next;
      str_st       <= str_st_next;
      string_ended <= string_ended_next;
      age_ok       <= age_ok_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_ends) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_adv && s1_ends) begin
      out_item <= res;
    end
  end

  // state is back at reset values after an element end
  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_ends) |=> (byte_count == '0 && str_st.value_count == '0 &&
                             str_st.in_leading_spaces && !string_ended && age_ok))
    else $error("element state not cleared after element end");

  // a new result is only loaded by an ending byte
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_adv && s1_ends))
    else $error("result appeared without an element end");

  // input is held back only by an element end waiting on the result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (s1_valid && s1_ends && out_valid && !out_ch.ready))
    else $error("input stalled without cause");

  // after a zero byte no component is open
  a_string_end_closed: assert property (@(posedge clk) disable iff (rst)
    string_ended |-> (str_st.component_length == '0 && !str_st.pending_spaces))
    else $error("component open after end of string");

endmodule

`default_nettype wire
